/* rtl/ftva_pkg.sv */
// fat tree vertex address decode: shared widths, codes, config and item types
// no dependencies
package ftva_pkg;

	localparam int ARITY_W  = 9;
	localparam int VERTEX_W = 23;
	localparam int HALF_W   = 8;
	localparam int HPP_W    = 15;
	localparam int QUOT_W   = 8;
	localparam int OCTET_W  = 8;

	localparam int MAX_ARITY   = 256;
	localparam int QUEUE_DEPTH = 16;

	localparam logic [1:0] KIND_HOST = 2'd0;
	localparam logic [1:0] KIND_EDGE = 2'd1;
	localparam logic [1:0] KIND_AGG  = 2'd2;
	localparam logic [1:0] KIND_CORE = 2'd3;

	// values derived from the reset arity
	localparam int RST_K          = 4;
	localparam int RST_HALF       = RST_K / 2;
	localparam int RST_HPP        = RST_HALF * RST_HALF;
	localparam int RST_PER_POD    = RST_HPP + RST_K;
	localparam int RST_EDGE_END   = RST_HPP + RST_HALF;
	localparam int RST_POD_REGION = RST_K * RST_PER_POD;
	localparam int RST_TOTAL      = RST_POD_REGION + RST_HPP;

	typedef struct packed {
		logic                ok;
		logic [ARITY_W-1:0]  k;
		logic [HALF_W-1:0]   half;
		logic [HPP_W-1:0]    hpp;
		logic [HPP_W-1:0]    per_pod;
		logic [HPP_W-1:0]    edge_end;
		logic [VERTEX_W-1:0] pod_region;
		logic [VERTEX_W-1:0] total;
	} cfg_t;

	typedef struct packed {
		logic               valid_res;
		logic [1:0]         kind;
		logic [ARITY_W-1:0] pod_octet;
		logic [HPP_W-1:0]   dividend;
		logic [OCTET_W-1:0] sidx;
	} mid_t;

	typedef struct packed {
		logic               valid_res;
		logic [1:0]         kind;
		logic [ARITY_W-1:0] pod_octet;
		logic [OCTET_W-1:0] third_octet;
		logic [OCTET_W-1:0] fourth_octet;
	} res_t;

endpackage

/* rtl/fat_tree_vertex_address_decode.sv */
// fat tree vertex address decode: top level, front end, middle queue, back end, result queue
// depends on ftva_pkg, ftva_cfg, ftva_front, ftva_fifo, ftva_back
// items pass the front stages, middle queue and back stages on the way to the result queue
// throughput: one item per cycle; full rises once front stages plus middle queue reach DEPTH
// reset: arst_n clears all queues and stage valids and sets the arity to 4
module fat_tree_vertex_address_decode #(
	parameter int DEPTH = ftva_pkg::QUEUE_DEPTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ftva_pkg::ARITY_W-1:0]  cfg_wdata,
	input  logic                          push,
	output logic                          full,
	input  logic [ftva_pkg::VERTEX_W-1:0] vertex_id,
	output logic                          empty,
	input  logic                          pop,
	output logic                          valid_res,
	output logic [1:0]                    kind,
	output logic [ftva_pkg::ARITY_W-1:0]  pod_octet,
	output logic [ftva_pkg::OCTET_W-1:0]  third_octet,
	output logic [ftva_pkg::OCTET_W-1:0]  fourth_octet
);
	import ftva_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	cfg_t          cfg;
	mid_t          mid_wr;
	mid_t          mid_rd;
	logic          mid_push;
	logic          mid_pop;
	logic          mid_empty;
	logic [CW-1:0] mid_count;
	res_t          out_wr;
	res_t          out_rd;
	logic          out_push;
	logic [CW-1:0] out_count;

	ftva_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	ftva_front #(.DEPTH(DEPTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.push      (push),
		.full      (full),
		.vertex_id (vertex_id),
		.mid_count (mid_count),
		.mid_push  (mid_push),
		.mid_item  (mid_wr)
	);

	ftva_fifo #(.DEPTH(DEPTH), .WIDTH($bits(mid_t))) u_mid_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mid_push),
		.wdata  (mid_wr),
		.pop    (mid_pop),
		.rdata  (mid_rd),
		.empty  (mid_empty),
		.count  (mid_count)
	);

	ftva_back #(.DEPTH(DEPTH)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.mid_empty (mid_empty),
		.mid_item  (mid_rd),
		.mid_pop   (mid_pop),
		.out_count (out_count),
		.out_push  (out_push),
		.out_item  (out_wr)
	);

	ftva_fifo #(.DEPTH(DEPTH), .WIDTH($bits(res_t))) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (out_push),
		.wdata  (out_wr),
		.pop    (pop),
		.rdata  (out_rd),
		.empty  (empty),
		.count  (out_count)
	);

	assign valid_res    = out_rd.valid_res;
	assign kind         = out_rd.kind;
	assign pod_octet    = out_rd.pod_octet;
	assign third_octet  = out_rd.third_octet;
	assign fourth_octet = out_rd.fourth_octet;

endmodule

/* rtl/ftva_fifo.sv */
// small first-word-fall-through queue with occupancy count
// depends on nothing but its parameters
module ftva_fifo #(
	parameter int DEPTH = 2,
	parameter int WIDTH = 1,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty,
	output logic [CW-1:0]    count
);

	logic [WIDTH-1:0] mem_q [0:DEPTH-1];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign do_push = push && (count_q != CW'(DEPTH));
	assign do_pop  = pop && (count_q != '0);
	assign empty   = (count_q == '0);
	assign count   = count_q;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!do_push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

/* rtl/ftva_cfg.sv */
// arity register and the tree sizes derived from it, one level per cycle
// depends on ftva_pkg
module ftva_cfg (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [ftva_pkg::ARITY_W-1:0]  cfg_wdata,
	output ftva_pkg::cfg_t                cfg
);
	import ftva_pkg::*;

	logic [ARITY_W-1:0]  k_q;
	logic                ok_q;
	logic [HALF_W-1:0]   half_q;
	logic [HPP_W-1:0]    hpp_q;
	logic [HPP_W-1:0]    per_pod_q;
	logic [HPP_W-1:0]    edge_end_q;
	logic [VERTEX_W-1:0] pod_region_q;
	logic [VERTEX_W-1:0] total_q;
	logic [HALF_W-1:0]   half_d;
	logic [2*HALF_W-1:0] hpp_d;

	assign half_d = k_q[ARITY_W-1:1];
	assign hpp_d  = half_d * half_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q          <= ARITY_W'(RST_K);
			ok_q         <= 1'b1;
			half_q       <= HALF_W'(RST_HALF);
			hpp_q        <= HPP_W'(RST_HPP);
			per_pod_q    <= HPP_W'(RST_PER_POD);
			edge_end_q   <= HPP_W'(RST_EDGE_END);
			pod_region_q <= VERTEX_W'(RST_POD_REGION);
			total_q      <= VERTEX_W'(RST_TOTAL);
		end else begin
			if (cfg_we) begin
				k_q <= cfg_wdata;
			end
			ok_q         <= (k_q != '0) && !k_q[0] && (k_q <= ARITY_W'(MAX_ARITY));
			half_q       <= half_d;
			hpp_q        <= hpp_d[HPP_W-1:0];
			per_pod_q    <= hpp_q + HPP_W'(k_q);
			edge_end_q   <= hpp_q + HPP_W'(half_q);
			pod_region_q <= VERTEX_W'(k_q) * VERTEX_W'(per_pod_q);
			total_q      <= pod_region_q + VERTEX_W'(hpp_q);
		end
	end

	assign cfg = '{
		ok:         ok_q,
		k:          k_q,
		half:       half_q,
		hpp:        hpp_q,
		per_pod:    per_pod_q,
		edge_end:   edge_end_q,
		pod_region: pod_region_q,
		total:      total_q
	};

endmodule

/* rtl/ftva_front.sv */
// front end: accepts vertex numbers, splits them by pod and classifies them
// depends on ftva_pkg; feeds the middle queue and reserves room in it
module ftva_front #(
	parameter int DEPTH = ftva_pkg::QUEUE_DEPTH,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ftva_pkg::cfg_t                cfg,
	input  logic                          push,
	output logic                          full,
	input  logic [ftva_pkg::VERTEX_W-1:0] vertex_id,
	input  logic [CW-1:0]                 mid_count,
	output logic                          mid_push,
	output ftva_pkg::mid_t                mid_item
);
	import ftva_pkg::*;

	logic                accept;
	logic [CW-1:0]       front_cnt_q;
	logic [CW:0]         used;
	logic                vld_s1;
	logic                vld_s2;
	logic [VERTEX_W-1:0] u_s1;
	logic [VERTEX_W-1:0] u_s2;

	// divider stages, index 0 is stage 3
	logic                dv_vld_s [0:QUOT_W];
	logic [VERTEX_W-1:0] dv_u_s   [0:QUOT_W];
	logic [VERTEX_W-1:0] dv_rem_s [0:QUOT_W];
	logic [QUOT_W-1:0]   dv_quo_s [0:QUOT_W];

	logic                in_range;
	logic                in_pods;
	logic                is_host;
	logic                is_edge;
	logic [VERTEX_W-1:0] core;
	logic [HPP_W-1:0]    os;
	logic [HPP_W-1:0]    sw;
	logic [VERTEX_W-1:0] u_f;

	assign accept = push && !full;
	assign used   = {1'b0, front_cnt_q} + {1'b0, mid_count};
	assign full   = (used >= (CW + 1)'(DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_cnt_q <= '0;
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			dv_vld_s[0] <= 1'b0;
		end else begin
			if (accept && !mid_push) begin
				front_cnt_q <= front_cnt_q + 1'b1;
			end else if (!accept && mid_push) begin
				front_cnt_q <= front_cnt_q - 1'b1;
			end
			vld_s1      <= accept;
			vld_s2      <= vld_s1;
			dv_vld_s[0] <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		u_s1        <= vertex_id;
		u_s2        <= u_s1;
		dv_u_s[0]   <= u_s2;
		dv_rem_s[0] <= u_s2;
		dv_quo_s[0] <= '0;
	end

	for (genvar j = 0; j < QUOT_W; j++) begin : g_step
		logic [VERTEX_W-1:0] dsh;
		logic                ge;

		assign dsh = VERTEX_W'(cfg.per_pod) << (QUOT_W - 1 - j);
		assign ge  = (dv_rem_s[j] >= dsh);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[j+1] <= 1'b0;
			end else begin
				dv_vld_s[j+1] <= dv_vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			dv_u_s[j+1]   <= dv_u_s[j];
			dv_rem_s[j+1] <= ge ? dv_rem_s[j] - dsh : dv_rem_s[j];
			dv_quo_s[j+1] <= dv_quo_s[j] | (ge ? QUOT_W'(1) << (QUOT_W - 1 - j) : '0);
		end
	end

	// classification
	assign u_f      = dv_u_s[QUOT_W];
	assign os       = dv_rem_s[QUOT_W][HPP_W-1:0];
	assign in_range = cfg.ok && (u_f < cfg.total);
	assign in_pods  = (u_f < cfg.pod_region);
	assign core     = u_f - cfg.pod_region;
	assign is_host  = (os < cfg.hpp);
	assign is_edge  = (os < cfg.edge_end);
	assign sw       = os - cfg.hpp;
	assign mid_push = dv_vld_s[QUOT_W];

	always_comb begin
		mid_item = '0;
		if (in_range) begin
			mid_item.valid_res = 1'b1;
			if (in_pods) begin
				mid_item.kind      = is_host ? KIND_HOST : (is_edge ? KIND_EDGE : KIND_AGG);
				mid_item.pod_octet = {1'b0, dv_quo_s[QUOT_W]};
				mid_item.dividend  = os;
				mid_item.sidx      = sw[OCTET_W-1:0];
			end else begin
				mid_item.kind      = KIND_CORE;
				mid_item.pod_octet = cfg.k;
				mid_item.dividend  = core[HPP_W-1:0];
			end
		end
	end

endmodule

/* rtl/ftva_back.sv */
// back end: divides the in-pod offset or core index by k/2 and forms the octets
// depends on ftva_pkg; drains the middle queue, fills the result queue
module ftva_back #(
	parameter int DEPTH = ftva_pkg::QUEUE_DEPTH,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic           clk,
	input  logic           arst_n,
	input  ftva_pkg::cfg_t cfg,
	input  logic           mid_empty,
	input  ftva_pkg::mid_t mid_item,
	output logic           mid_pop,
	input  logic [CW-1:0]  out_count,
	output logic           out_push,
	output ftva_pkg::res_t out_item
);
	import ftva_pkg::*;

	logic [CW-1:0]     back_cnt_q;
	logic [CW:0]       used;

	logic              bk_vld_s  [0:QUOT_W];
	mid_t              bk_item_s [0:QUOT_W];
	logic [HPP_W-1:0]  bk_rem_s  [0:QUOT_W];
	logic [QUOT_W-1:0] bk_quo_s  [0:QUOT_W];

	mid_t              fin;
	logic [QUOT_W-1:0] quo;
	logic [OCTET_W-1:0] rem;

	assign used    = {1'b0, back_cnt_q} + {1'b0, out_count};
	assign mid_pop = !mid_empty && (used < (CW + 1)'(DEPTH));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			back_cnt_q  <= '0;
			bk_vld_s[0] <= 1'b0;
		end else begin
			if (mid_pop && !out_push) begin
				back_cnt_q <= back_cnt_q + 1'b1;
			end else if (!mid_pop && out_push) begin
				back_cnt_q <= back_cnt_q - 1'b1;
			end
			bk_vld_s[0] <= mid_pop;
		end
	end

	always_ff @(posedge clk) begin
		bk_item_s[0] <= mid_item;
		bk_rem_s[0]  <= mid_item.dividend;
		bk_quo_s[0]  <= '0;
	end

	for (genvar j = 0; j < QUOT_W; j++) begin : g_step
		logic [HPP_W-1:0] dsh;
		logic             ge;

		assign dsh = HPP_W'(cfg.half) << (QUOT_W - 1 - j);
		assign ge  = (bk_rem_s[j] >= dsh);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				bk_vld_s[j+1] <= 1'b0;
			end else begin
				bk_vld_s[j+1] <= bk_vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			bk_item_s[j+1] <= bk_item_s[j];
			bk_rem_s[j+1]  <= ge ? bk_rem_s[j] - dsh : bk_rem_s[j];
			bk_quo_s[j+1]  <= bk_quo_s[j] | (ge ? QUOT_W'(1) << (QUOT_W - 1 - j) : '0);
		end
	end

	assign fin      = bk_item_s[QUOT_W];
	assign quo      = bk_quo_s[QUOT_W];
	assign rem      = bk_rem_s[QUOT_W][OCTET_W-1:0];
	assign out_push = bk_vld_s[QUOT_W];

	always_comb begin
		out_item = '0;
		if (fin.valid_res) begin
			out_item.valid_res = 1'b1;
			out_item.kind      = fin.kind;
			out_item.pod_octet = fin.pod_octet;
			unique case (fin.kind)
				KIND_HOST: begin
					out_item.third_octet  = quo;
					out_item.fourth_octet = rem + OCTET_W'(2);
				end
				KIND_CORE: begin
					out_item.third_octet  = quo + OCTET_W'(1);
					out_item.fourth_octet = rem + OCTET_W'(1);
				end
				default: begin
					out_item.third_octet  = fin.sidx;
					out_item.fourth_octet = OCTET_W'(1);
				end
			endcase
		end
	end

endmodule

/* rtl/ftva_checker.sv */
// port-level checks on the fat tree vertex address decode results
// depends on ftva_pkg; bound to fat_tree_vertex_address_decode
module ftva_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          empty,
	input logic                          pop,
	input logic                          valid_res,
	input logic [1:0]                    kind,
	input logic [ftva_pkg::ARITY_W-1:0]  pod_octet,
	input logic [ftva_pkg::OCTET_W-1:0]  third_octet,
	input logic [ftva_pkg::OCTET_W-1:0]  fourth_octet
);
	import ftva_pkg::*;

	// invalid items carry all-zero fields
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !valid_res |-> kind == KIND_HOST && pod_octet == '0 &&
			third_octet == '0 && fourth_octet == '0)
		else $error("invalid item with nonzero fields");

	// pod switches always end in .1
	a_switch_fourth: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && valid_res && (kind == KIND_EDGE || kind == KIND_AGG) |->
			fourth_octet == OCTET_W'(1))
		else $error("pod switch fourth octet not 1");

	// hosts start at .2, core indexes start at 1
	a_host_core_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && valid_res |->
			(kind != KIND_HOST || fourth_octet >= OCTET_W'(2)) &&
			(kind != KIND_CORE || (third_octet != '0 && fourth_octet != '0)))
		else $error("host or core octet out of range");

	// a waiting item stays put until popped
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(valid_res) && $stable(kind) &&
			$stable(pod_octet) && $stable(third_octet) && $stable(fourth_octet))
		else $error("waiting item changed");

endmodule

bind fat_tree_vertex_address_decode ftva_checker u_ftva_checker (.*);

/* tb/sv/fat_tree_vertex_address_decode_test.sv */
// testbench for fat_tree_vertex_address_decode: directed table and random vertex stream,
// results checked in order against the table or a local address decoder, several arities
// depends on ftva_pkg and the fat_tree_vertex_address_decode rtl
`timescale 1ns / 1ps

module fat_tree_vertex_address_decode_test;
	import ftva_pkg::*;

	localparam int NPROBE         = 26;
	localparam int NPHASE         = 12;
	localparam int ITEMS_PER_PHASE = 137;
	localparam int SETTLE_CYCLES  = 40;
	localparam int CYCLE_LIMIT    = 400000;
	localparam int unsigned FULL_SPAN = 4276224;

	typedef struct packed {
		logic [ARITY_W-1:0]  arity;
		logic [VERTEX_W-1:0] vertex;
		logic                known;
		res_t                want;
	} probe_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [ARITY_W-1:0]  cfg_wdata = '0;
	logic                push = 1'b0;
	logic                full;
	logic [VERTEX_W-1:0] vertex_id = '0;
	logic                empty;
	logic                pop = 1'b0;
	logic                valid_res;
	logic [1:0]          kind;
	logic [ARITY_W-1:0]  pod_octet;
	logic [OCTET_W-1:0]  third_octet;
	logic [OCTET_W-1:0]  fourth_octet;

	logic                row_known = 1'b0;
	res_t                row_want = '0;
	logic [ARITY_W-1:0]  cur_arity = 9'd4;
	bit                  calm = 1'b0;
	int                  stall_left = 0;
	int                  mismatches = 0;
	int unsigned         cycles = 0;
	res_t                awaited_addresses[$];
	probe_t              probe_table[NPROBE];

	fat_tree_vertex_address_decode DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.push        (push),
		.full        (full),
		.vertex_id   (vertex_id),
		.empty       (empty),
		.pop         (pop),
		.valid_res   (valid_res),
		.kind        (kind),
		.pod_octet   (pod_octet),
		.third_octet (third_octet),
		.fourth_octet(fourth_octet)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("fat_tree_vertex_address_decode test failed");
			$finish;
		end
	end

	function automatic res_t decode_vertex(input logic [ARITY_W-1:0] arity,
		input logic [VERTEX_W-1:0] vertex);
		int unsigned k, v, half, hpp, per_pod, pod_region, offset, core;
		res_t r;
		k = 32'(arity);
		v = 32'(vertex);
		r = '0;
		if (k != 0 && k % 2 == 0 && k <= MAX_ARITY) begin
			half = k / 2;
			hpp = k * k / 4;
			per_pod = hpp + k;
			pod_region = k * per_pod;
			if (v < pod_region + hpp) begin
				r.valid_res = 1'b1;
				if (v < pod_region) begin
					offset = v % per_pod;
					r.pod_octet = ARITY_W'(v / per_pod);
					if (offset < hpp) begin
						r.kind = KIND_HOST;
						r.third_octet = OCTET_W'(offset / half);
						r.fourth_octet = OCTET_W'(offset % half + 2);
					end else begin
						offset = offset - hpp;
						r.kind = (offset < half) ? KIND_EDGE : KIND_AGG;
						r.third_octet = OCTET_W'(offset);
						r.fourth_octet = OCTET_W'(1);
					end
				end else begin
					core = v - pod_region;
					r.kind = KIND_CORE;
					r.pod_octet = ARITY_W'(k);
					r.third_octet = OCTET_W'(core / half + 1);
					r.fourth_octet = OCTET_W'(core % half + 1);
				end
			end
		end
		return r;
	endfunction

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	function automatic void note_expected(input res_t r);
		awaited_addresses.insert(awaited_addresses.size(), r);
	endfunction

	// scoreboard: predict on accepted item, compare on accepted result
	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				got = {valid_res, kind, pod_octet, third_octet, fourth_octet};
				if (awaited_addresses.size() == 0) begin
					$display("%0t: unexpected result: expected none, actual %h", $time, got);
					mismatches++;
				end else begin
					want = awaited_addresses.pop_front();
					check_field("valid_res", 32'(want.valid_res), 32'(got.valid_res));
					check_field("kind", 32'(want.kind), 32'(got.kind));
					check_field("pod_octet", 32'(want.pod_octet), 32'(got.pod_octet));
					check_field("third_octet", 32'(want.third_octet), 32'(got.third_octet));
					check_field("fourth_octet", 32'(want.fourth_octet),
						32'(got.fourth_octet));
				end
			end
			if (push && !full)
				note_expected(row_known ? row_want : decode_vertex(cur_arity, vertex_id));
		end
	end

	// result side stalls in bursts
	always @(negedge clk) begin
		if (stall_left != 0 && !calm) begin
			stall_left <= stall_left - 1;
			pop <= 1'b0;
		end else if (!calm && $urandom_range(0, 9) == 0) begin
			stall_left <= int'($urandom_range(0, 18));
			pop <= 1'b0;
		end else begin
			stall_left <= 0;
			pop <= 1'b1;
		end
	end

	task automatic supply_vertex(input logic [VERTEX_W-1:0] v, input logic known, input res_t want);
		int unsigned gap;
		if (!calm && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 19);
			push <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		push <= 1'b1;
		vertex_id <= v;
		row_known <= known;
		row_want <= want;
		@(posedge clk);
		while (full) @(posedge clk);
		@(negedge clk);
	endtask

	// wait for every item to come back, then change the arity
	task automatic settle_arity(input logic [ARITY_W-1:0] k);
		push <= 1'b0;
		while (awaited_addresses.size() != 0) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= k;
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_arity = k;
	endtask

	initial begin
		logic [ARITY_W-1:0]  phase_k;
		logic [VERTEX_W-1:0] v;
		int unsigned         k, span, pick;
		probe_table[0]  = {9'd4, 23'd0, 1'b1, 1'b1, KIND_HOST, 9'd0, 8'd0, 8'd2};
		probe_table[1]  = {9'd4, 23'd1, 1'b1, 1'b1, KIND_HOST, 9'd0, 8'd0, 8'd3};
		probe_table[2]  = {9'd4, 23'd3, 1'b1, 1'b1, KIND_HOST, 9'd0, 8'd1, 8'd3};
		probe_table[3]  = {9'd4, 23'd4, 1'b1, 1'b1, KIND_EDGE, 9'd0, 8'd0, 8'd1};
		probe_table[4]  = {9'd4, 23'd6, 1'b1, 1'b1, KIND_AGG, 9'd0, 8'd2, 8'd1};
		probe_table[5]  = {9'd4, 23'd31, 1'b1, 1'b1, KIND_AGG, 9'd3, 8'd3, 8'd1};
		probe_table[6]  = {9'd4, 23'd32, 1'b1, 1'b1, KIND_CORE, 9'd4, 8'd1, 8'd1};
		probe_table[7]  = {9'd4, 23'd35, 1'b1, 1'b1, KIND_CORE, 9'd4, 8'd2, 8'd2};
		probe_table[8]  = {9'd4, 23'd36, 1'b1, 28'd0};
		probe_table[9]  = {9'd4, 23'd8388607, 1'b1, 28'd0};
		probe_table[10] = {9'd4, 23'd5, 1'b0, 28'd0};
		probe_table[11] = {9'd4, 23'd20, 1'b0, 28'd0};
		probe_table[12] = {9'd2, 23'd0, 1'b1, 1'b1, KIND_HOST, 9'd0, 8'd0, 8'd2};
		probe_table[13] = {9'd2, 23'd1, 1'b1, 1'b1, KIND_EDGE, 9'd0, 8'd0, 8'd1};
		probe_table[14] = {9'd2, 23'd2, 1'b1, 1'b1, KIND_AGG, 9'd0, 8'd1, 8'd1};
		probe_table[15] = {9'd2, 23'd6, 1'b1, 1'b1, KIND_CORE, 9'd2, 8'd1, 8'd1};
		probe_table[16] = {9'd2, 23'd7, 1'b1, 28'd0};
		probe_table[17] = {9'd256, 23'd0, 1'b1, 1'b1, KIND_HOST, 9'd0, 8'd0, 8'd2};
		probe_table[18] = {9'd256, 23'd4276223, 1'b1, 1'b1, KIND_CORE, 9'd256, 8'd128, 8'd128};
		probe_table[19] = {9'd256, 23'd4276224, 1'b1, 28'd0};
		probe_table[20] = {9'd256, 23'd4259839, 1'b1, 1'b1, KIND_AGG, 9'd255, 8'd255, 8'd1};
		probe_table[21] = {9'd256, 23'd16383, 1'b1, 1'b1, KIND_HOST, 9'd0, 8'd127, 8'd129};
		probe_table[22] = {9'd0, 23'd0, 1'b1, 28'd0};
		probe_table[23] = {9'd3, 23'd0, 1'b1, 28'd0};
		probe_table[24] = {9'd258, 23'd0, 1'b1, 28'd0};
		probe_table[25] = {9'd511, 23'd8388607, 1'b1, 28'd0};

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < NPROBE; i++) begin
			if (probe_table[i].arity != cur_arity)
				settle_arity(probe_table[i].arity);
			supply_vertex(probe_table[i].vertex, probe_table[i].known, probe_table[i].want);
		end

		for (int p = 0; p < NPHASE; p++) begin
			if (p == 0)
				phase_k = 9'd256;
			else if (p == 1)
				phase_k = 9'd2;
			else if (p != NPHASE - 1 && $urandom_range(0, 7) == 0)
				phase_k = ARITY_W'($urandom_range(0, 511));
			else
				phase_k = ARITY_W'(2 * $urandom_range(1, 128));
			settle_arity(phase_k);
			calm = (p == NPHASE - 1);
			k = 32'(phase_k);
			if (k != 0 && k % 2 == 0 && k <= MAX_ARITY)
				span = k * (k * k / 4 + k) + k * k / 4;
			else
				span = FULL_SPAN;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				pick = $urandom_range(0, 15);
				if (pick == 0)
					v = VERTEX_W'($urandom);
				else if (pick == 1)
					v = VERTEX_W'(span + $urandom_range(0, 3));
				else if (pick == 2)
					v = VERTEX_W'(span - 1 - $urandom_range(0, 3));
				else
					v = VERTEX_W'($urandom_range(0, span - 1));
				supply_vertex(v, 1'b0, '0);
			end
		end

		push <= 1'b0;
		while (awaited_addresses.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatches == 0)
			$display("fat_tree_vertex_address_decode test passed");
		else
			$display("fat_tree_vertex_address_decode test failed");
		$finish;
	end

endmodule
